// ----- sv/ema_pkg.sv -----
// Package for the error metrics accumulator: payload structs, constants and
// the front-to-back queue entry type. No dependencies.
package ema_pkg;

   localparam int unsigned DefaultMaxSize = 64;
   localparam logic [6:0]  SizeReset      = 7'd21;
   localparam logic [31:0] RelScale       = 32'd6553600;   // 100 << 16
   localparam logic [30:0] Sat31          = 31'h7FFF_FFFF;
   localparam logic [1:0]  CsrAddrSize    = 2'd0;

   typedef struct packed {
      logic signed [31:0] model_value;
      logic signed [31:0] market_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] abs_error;
      logic signed [31:0] rel_error_pct;
      logic               div_fault;
      logic               last;
      logic [30:0]        rms_error;
      logic [30:0]        mean_abs_error;
      logic [30:0]        max_abs_error;
      logic [5:0]         max_abs_row;
      logic [5:0]         max_abs_col;
      logic [30:0]        max_rel_error;
      logic [5:0]         max_rel_row;
      logic [5:0]         max_rel_col;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic               dneg;     // error negative
      logic [32:0]        dmag;     // exact error magnitude
      logic               mneg;
      logic [31:0]        mmag;     // reference magnitude
      logic               first;    // frame start
      logic               last;
      logic [5:0]         row;
      logic [5:0]         col;
   } work_type;

endpackage

// ----- sv/ema_front.sv -----
// Front end: takes items, walks the triangle and classifies each pair.
// Depends on ema_pkg.
module ema_front
   import ema_pkg::*;
#(
   parameter int unsigned MAX_SIZE = DefaultMaxSize
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     cfg_we,
   input  logic [6:0] cfg_size,
   input  logic     req_push,
   input  req_type  req_data,
   input  logic     fifo_full,
   output logic     req_full,
   output logic     fifo_push,
   output work_type fifo_data
);
   localparam int unsigned MaxSizeClip = (MAX_SIZE > 127) ? 127 : MAX_SIZE;

   // walk counters span the full size register; positions report the low 6 bits
   logic [6:0] row_ff, row_in, col_ff, col_in;
   logic [6:0] size;
   logic signed [32:0] diff;
   logic [7:0] col_lim;
   logic       step_col;

   always_comb begin
      size = cfg_size;
      if (size < 7'd3) size = 7'd3;
      if (size > 7'(MaxSizeClip)) size = 7'(MaxSizeClip);
   end

   assign req_full  = fifo_full;
   assign fifo_push = req_push && !fifo_full;
   assign diff = 33'(req_data.model_value) - 33'(req_data.market_value);
   assign col_lim  = {1'b0, size} - {1'b0, row_ff} - 8'd1;
   assign step_col = ({1'b0, col_ff} + 8'd1 <= col_lim) &&
                     ({1'b0, row_ff} + 8'd1 < {1'b0, size});

   always_comb begin
      fifo_data.dneg  = diff[32];
      fifo_data.dmag  = diff[32] ? 33'(-diff) : 33'(diff);
      fifo_data.mneg  = req_data.market_value[31];
      fifo_data.mmag  = req_data.market_value[31] ? 32'(-req_data.market_value)
                                                  : 32'(req_data.market_value);
      fifo_data.first = (row_ff == 7'd1) && (col_ff == 7'd1);
      fifo_data.last  = !step_col && ({1'b0, row_ff} + 8'd2 >= {1'b0, size});
      fifo_data.row   = row_ff[5:0];
      fifo_data.col   = col_ff[5:0];
      row_in = row_ff;
      col_in = col_ff;
      if (fifo_push) begin
         if (step_col) begin
            col_in = col_ff + 7'd1;
         end else begin
            col_in = 7'd1;
            row_in = fifo_data.last ? 7'd1 : row_ff + 7'd1;
         end
      end
      if (cfg_we) begin
         row_in = 7'd1;
         col_in = 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= 7'd1;
         col_ff <= 7'd1;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end
endmodule

// ----- sv/ema_queue.sv -----
// Two-entry queue between front and back. Depends on ema_pkg.
module ema_queue
   import ema_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output work_type pop_data
);
   work_type   mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ----- sv/ema_divider.sv -----
// Shared restoring divider, one quotient bit per cycle, 64/64 bits.
// Depends on ema_pkg.
module ema_divider
   import ema_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        busy,
   output logic [63:0] quotient
);
   logic [63:0] rem_ff, quo_ff, den_ff;
   logic [6:0]  cnt_ff;
   logic [64:0] trial;

   assign busy     = cnt_ff != 7'd0;
   assign quotient = quo_ff;
   assign trial    = {rem_ff, quo_ff[63]} - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 7'd0;
      end else if (start) begin
         cnt_ff <= 7'd64;
      end else if (busy) begin
         cnt_ff <= cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= 64'd0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy) begin
         if (!trial[64]) begin
            rem_ff <= trial[63:0];
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[62:0], quo_ff[63]};
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
   end
endmodule

// ----- sv/ema_back.sv -----
// Back end: relative error, accumulation, maxima and frame summaries.
// Uses ema_divider for every quotient and an iterative square root.
// Depends on ema_pkg and ema_divider.
module ema_back
   import ema_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  work_type q_data,
   output logic     q_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_SQ, S_REL_GO, S_REL_WAIT, S_UPD, S_RMS_GO, S_RMS_WAIT,
      S_SQRT, S_MEAN_GO, S_MEAN_WAIT, S_OUT
   } state_type;

   state_type   state_ff;
   work_type    w_ff;
   logic [63:0] sumsq_ff, sq_ff, prod_ff, sqv_ff, res_ff, bit_ff;
   logic [47:0] summ_ff;
   logic [10:0] cnt_ff;
   logic [30:0] labs_ff, lrel_ff, emag_ff;
   logic [11:0] labs_pos_ff, lrel_pos_ff;
   logic        full_ff;
   rsp_type     out_ff;
   logic        div_start;
   logic [63:0] div_a, div_b, div_q;
   logic        div_busy;
   logic [30:0] rmag;
   logic [31:0] rel_val;
   logic [64:0] sq_sum;

   ema_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .busy(div_busy), .quotient(div_q));

   assign div_start = state_ff == S_REL_GO || state_ff == S_RMS_GO || state_ff == S_MEAN_GO;
   always_comb begin
      div_a = prod_ff;
      div_b = {32'd0, w_ff.mmag};
      if (state_ff == S_RMS_GO) begin
         div_a = sumsq_ff;
         div_b = {53'd0, cnt_ff};
      end else if (state_ff == S_MEAN_GO) begin
         div_a = {16'd0, summ_ff};
         div_b = {53'd0, cnt_ff};
      end
   end

   // relative error value (signed pattern) from the quotient
   always_comb begin
      if (w_ff.mmag == 32'd0) begin
         if (w_ff.dmag == 33'd0) rel_val = 32'd0;
         else rel_val = w_ff.dneg ? 32'h8000_0000 : {1'b0, Sat31};
      end else if (w_ff.dneg != w_ff.mneg) begin
         rel_val = (div_q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-div_q[31:0]);
      end else begin
         rel_val = (div_q > {33'd0, Sat31}) ? {1'b0, Sat31} : div_q[31:0];
      end
      if (rel_val[31]) begin
         rmag = (rel_val == 32'h8000_0000) ? Sat31 : 31'(-rel_val);
      end else begin
         rmag = rel_val[30:0];
      end
   end

   assign sq_sum    = {1'b0, sumsq_ff} + {1'b0, sq_ff};
   assign q_pop     = state_ff == S_IDLE && !q_empty && !full_ff;
   assign rsp_empty = !full_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         full_ff  <= 1'b0;
         sumsq_ff <= 64'd0;
         summ_ff  <= 48'd0;
         cnt_ff   <= 11'd0;
         labs_ff  <= 31'd0;
         lrel_ff  <= 31'd0;
         labs_pos_ff <= 12'd0;
         lrel_pos_ff <= 12'd0;
      end else begin
         if (rsp_pop && full_ff) full_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  w_ff    <= q_data;
                  emag_ff <= (q_data.dmag > {2'b0, Sat31}) ? Sat31 : q_data.dmag[30:0];
                  prod_ff <= 64'(q_data.dmag) * 64'(RelScale);
                  if (q_data.first) begin
                     sumsq_ff <= 64'd0;
                     summ_ff  <= 48'd0;
                     cnt_ff   <= 11'd0;
                     labs_ff  <= 31'd0;
                     lrel_ff  <= 31'd0;
                     labs_pos_ff <= 12'd0;
                     lrel_pos_ff <= 12'd0;
                  end
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               sq_ff    <= 64'(emag_ff) * 64'(emag_ff);
               state_ff <= S_REL_GO;
            end
            S_REL_GO:   state_ff <= S_REL_WAIT;
            S_REL_WAIT: if (!div_busy) state_ff <= S_UPD;
            S_UPD: begin
               sumsq_ff <= sq_sum[64] ? '1 : sq_sum[63:0];
               summ_ff  <= summ_ff + 48'(emag_ff);
               cnt_ff   <= cnt_ff + 11'd1;
               if (rmag > lrel_ff) begin
                  lrel_ff <= rmag;
                  lrel_pos_ff <= {w_ff.row, w_ff.col};
               end
               if (emag_ff > labs_ff) begin
                  labs_ff <= emag_ff;
                  labs_pos_ff <= {w_ff.row, w_ff.col};
               end
               out_ff.abs_error     <= w_ff.dneg ? ((w_ff.dmag >= 33'h8000_0000) ?
                                       32'h8000_0000 : 32'(-w_ff.dmag)) :
                                       {1'b0, emag_ff};
               out_ff.rel_error_pct <= rel_val;
               out_ff.div_fault     <= w_ff.mmag == 32'd0;
               out_ff.last          <= w_ff.last;
               out_ff.rms_error     <= 31'd0;
               out_ff.mean_abs_error <= 31'd0;
               state_ff <= (w_ff.last && cnt_ff != 11'h7FF) ? S_RMS_GO : S_OUT;
            end
            S_RMS_GO:   state_ff <= S_RMS_WAIT;
            S_RMS_WAIT: begin
               if (!div_busy) begin
                  sqv_ff   <= div_q;
                  res_ff   <= 64'd0;
                  bit_ff   <= 64'd1 << 62;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               // one result bit per cycle
               if (bit_ff == 64'd0) begin
                  out_ff.rms_error <= (res_ff > {33'd0, Sat31}) ? Sat31 : res_ff[30:0];
                  state_ff <= S_MEAN_GO;
               end else begin
                  if (sqv_ff >= res_ff + bit_ff) begin
                     sqv_ff <= sqv_ff - (res_ff + bit_ff);
                     res_ff <= (res_ff >> 1) + bit_ff;
                  end else begin
                     res_ff <= res_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end
            end
            S_MEAN_GO:   state_ff <= S_MEAN_WAIT;
            S_MEAN_WAIT: begin
               if (!div_busy) begin
                  out_ff.mean_abs_error <= (div_q > {33'd0, Sat31}) ? Sat31 : div_q[30:0];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!full_ff || rsp_pop) begin
                  out_ff.max_abs_error <= labs_ff;
                  out_ff.max_abs_row   <= labs_pos_ff[11:6];
                  out_ff.max_abs_col   <= labs_pos_ff[5:0];
                  out_ff.max_rel_error <= lrel_ff;
                  out_ff.max_rel_row   <= lrel_pos_ff[11:6];
                  out_ff.max_rel_col   <= lrel_pos_ff[5:0];
                  full_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- sv/error_metrics_accumulator.sv -----
// Top level of the error metrics accumulator: CSR port, front end, queue,
// back end. Depends on ema_pkg, ema_front, ema_queue, ema_back.
//
// Usage: push model/reference pairs (req_) while req_full is low, in the
// upper-triangular walk order of a matrix of edge matrix_size; the block
// tracks row and column itself. Each item yields one result on rsp_ with
// the signed and percent relative errors, running maxima with positions,
// and on the frame's last item the RMS and mean absolute error.
// Each item's relative error comes from the shared 64-step radix-2 divider;
// the last item of a frame adds two more divides and a 32-step square root.
// Front end and a 2-entry queue keep accepting while the back end works.
// A finished result waits in the output register until popped; while it
// waits the back end holds and the queue fills, then req_full rises.
// Reset: matrix_size is 21, walk at (1,1), accumulators and queue clear.
// Writing matrix_size (address 0) restarts the walk; write only when idle.
module error_metrics_accumulator
   import ema_pkg::*;
#(
   parameter int unsigned MAX_SIZE = DefaultMaxSize
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [6:0] size_ff;
   logic       cfg_we;
   logic       q_full, q_push, q_pop, q_empty;
   work_type   q_in, q_out;

   assign csr_pready = 1'b1;
   assign cfg_we = csr_psel && csr_penable && csr_pwrite && csr_paddr == CsrAddrSize;
   assign csr_prdata = (csr_paddr == CsrAddrSize) ? {25'd0, size_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SizeReset;
      end else if (cfg_we) begin
         size_ff <= csr_pwdata[6:0];
      end
   end

   ema_front #(.MAX_SIZE(MAX_SIZE)) u_front (
      .clock(clock), .reset(reset), .cfg_we(cfg_we), .cfg_size(size_ff),
      .req_push(req_push), .req_data(req_data), .fifo_full(q_full),
      .req_full(req_full), .fifo_push(q_push), .fifo_data(q_in));

   ema_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in),
      .full(q_full), .pop(q_pop), .empty(q_empty), .pop_data(q_out));

   ema_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_data(q_out),
      .q_pop(q_pop), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_data(rsp_data));
endmodule
